@@ rtl/rpaa_pkg.sv @@
// Constants, types and helpers for the point-about-axis rotation pipeline.
// No dependencies; used by rotate_point_about_axis_unit.
package rpaa_pkg;

	localparam int CordicSteps = 24;
	localparam int CwW = 34;                       // CORDIC x/y/z width
	localparam logic signed [CwW-1:0] CordicGain = 34'sd652032874;

	typedef logic signed [CwW-1:0] cw_t;

	// Item fields that ride alongside the CORDIC stages.
	typedef struct packed {
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
		logic signed [23:0] px;
		logic signed [23:0] py;
		logic signed [23:0] pz;
		logic signed [40:0] crx;
		logic signed [40:0] cry;
		logic signed [40:0] crz;
		logic signed [27:0] dot;
		logic [1:0]         quad;
	} dly_t;

	function automatic cw_t atan_of(input logic [4:0] i);
		cw_t r;
		r = '0;
		case (i)
			5'd0:  r = 34'sd536870912;
			5'd1:  r = 34'sd316933406;
			5'd2:  r = 34'sd167458907;
			5'd3:  r = 34'sd85004756;
			5'd4:  r = 34'sd42667331;
			5'd5:  r = 34'sd21354465;
			5'd6:  r = 34'sd10679838;
			5'd7:  r = 34'sd5340245;
			5'd8:  r = 34'sd2670163;
			5'd9:  r = 34'sd1335087;
			5'd10: r = 34'sd667544;
			5'd11: r = 34'sd333772;
			5'd12: r = 34'sd166886;
			5'd13: r = 34'sd83443;
			5'd14: r = 34'sd41722;
			5'd15: r = 34'sd20861;
			5'd16: r = 34'sd10430;
			5'd17: r = 34'sd5215;
			5'd18: r = 34'sd2608;
			5'd19: r = 34'sd1304;
			5'd20: r = 34'sd652;
			5'd21: r = 34'sd326;
			5'd22: r = 34'sd163;
			5'd23: r = 34'sd81;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Round Q2.30 to Q16 and clamp to one full unit either way.
	function automatic logic signed [17:0] trig_q16(input cw_t v);
		logic signed [CwW:0] t;
		logic signed [20:0]  q;
		logic signed [17:0]  r;
		t = CwW'(v) + (CwW+1)'(8192);
		q = 21'(t >>> 14);
		if (q > 21'sd65536)       r = 18'sd65536;
		else if (q < -21'sd65536) r = -18'sd65536;
		else                      r = 18'(q);
		return r;
	endfunction

	// Round Q46 to Q16 and saturate to 24 bits.
	function automatic logic signed [23:0] round_sat(input logic signed [63:0] acc);
		logic signed [63:0] t;
		logic signed [33:0] q;
		logic signed [23:0] r;
		t = acc + 64'sd536870912;
		q = 34'(t >>> 30);
		if (q > 34'sd8388607)       r = 24'sd8388607;
		else if (q < -34'sd8388608) r = -24'sd8388608;
		else                        r = 24'(q);
		return r;
	endfunction

endpackage

@@ rtl/rotate_point_about_axis_unit.sv @@
// Top level: Rodrigues rotation of a Q8.16 point about a Q1.14 unit axis.
// Depends on rpaa_pkg (CORDIC table, stage types, rounding helpers).
//
// Usage:
//   Input beats arrive on s_tvalid/s_tready/s_tdata carrying axis, angle and
//   point; one output beat per input leaves on m_tvalid/m_tready/m_tdata with
//   the rotated point, in input order.
//   Throughput is one beat per clock while the output is not stalled:
//   24 pipelined CORDIC steps produce sine and cosine,
//   while the cross and dot products ride alongside; four further stages
//   fold in the quadrant, scale, multiply by (1 - cos), sum, round and
//   saturate.
//   The whole pipeline advances as one unit whenever the output register is
//   empty or being taken; when the receiver stalls with a beat waiting, every
//   stage holds and s_tready drops in the same cycle, so nothing is lost or
//   repeated. Bubbles ahead of a held output are not squeezed out.
//   Reset (arst_n low) clears all valid bits at once; data registers are left
//   as they are. The block has no internal state between beats.
module rotate_point_about_axis_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// axis_x[15:0] axis_y[31:16] axis_z[47:32] angle[63:48]
	// point_x[87:64] point_y[111:88] point_z[135:112]
	input  logic [135:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// rotated_x[23:0] rotated_y[47:24] rotated_z[71:48]
	output logic [71:0]  m_tdata
);

	localparam int NStg = rpaa_pkg::CordicSteps + 4;

	logic            en;
	logic [NStg:1]   vld_s;

	// Advance everything unless a result is held at the output.
	assign en       = !vld_s[NStg] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_s[NStg];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NStg-1:1], s_tvalid};
		end
	end

	// Unpack the input beat.
	logic signed [15:0] in_ax, in_ay, in_az;
	logic [15:0]        in_ang;
	logic signed [23:0] in_px, in_py, in_pz;
	assign in_ax  = s_tdata[15:0];
	assign in_ay  = s_tdata[31:16];
	assign in_az  = s_tdata[47:32];
	assign in_ang = s_tdata[63:48];
	assign in_px  = s_tdata[87:64];
	assign in_py  = s_tdata[111:88];
	assign in_pz  = s_tdata[135:112];

	// Stage 1: the nine axis-by-point products.
	logic signed [39:0] pxx_s1, pyy_s1, pzz_s1;
	logic signed [39:0] ayz_s1, azy_s1, azx_s1, axz_s1, axy_s1, ayx_s1;
	logic signed [15:0] ax_s1, ay_s1, az_s1;
	logic signed [23:0] px_s1, py_s1, pz_s1;
	logic [1:0]         quad_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			pxx_s1  <= in_ax * in_px;
			pyy_s1  <= in_ay * in_py;
			pzz_s1  <= in_az * in_pz;
			ayz_s1  <= in_ay * in_pz;
			azy_s1  <= in_az * in_py;
			azx_s1  <= in_az * in_px;
			axz_s1  <= in_ax * in_pz;
			axy_s1  <= in_ax * in_py;
			ayx_s1  <= in_ay * in_px;
			ax_s1   <= in_ax;
			ay_s1   <= in_ay;
			az_s1   <= in_az;
			px_s1   <= in_px;
			py_s1   <= in_py;
			pz_s1   <= in_pz;
			quad_s1 <= in_ang[15:14];
		end
	end

	// Stage 2: cross product and rounded dot product, then delay to stage 25.
	rpaa_pkg::dly_t     dl_s [2:rpaa_pkg::CordicSteps+1];
	rpaa_pkg::dly_t     dl_in;
	logic signed [41:0] dsum;

	always_comb begin
		dsum      = 42'(pxx_s1) + 42'(pyy_s1) + 42'(pzz_s1) + 42'sd8192;
		dl_in.ax  = ax_s1;
		dl_in.ay  = ay_s1;
		dl_in.az  = az_s1;
		dl_in.px  = px_s1;
		dl_in.py  = py_s1;
		dl_in.pz  = pz_s1;
		dl_in.crx = 41'(ayz_s1) - 41'(azy_s1);
		dl_in.cry = 41'(azx_s1) - 41'(axz_s1);
		dl_in.crz = 41'(axy_s1) - 41'(ayx_s1);
		dl_in.dot = 28'(dsum >>> 14);
		dl_in.quad = quad_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dl_s[2] <= dl_in;
			for (int k = 3; k <= rpaa_pkg::CordicSteps + 1; k++) begin
				dl_s[k] <= dl_s[k-1];
			end
		end
	end

	// Stages 1..24: one CORDIC micro-rotation per stage on the residual angle.
	rpaa_pkg::cw_t cx [0:rpaa_pkg::CordicSteps];
	rpaa_pkg::cw_t cy [0:rpaa_pkg::CordicSteps];
	rpaa_pkg::cw_t cz [0:rpaa_pkg::CordicSteps];
	rpaa_pkg::cw_t x_s [1:rpaa_pkg::CordicSteps];
	rpaa_pkg::cw_t y_s [1:rpaa_pkg::CordicSteps];
	rpaa_pkg::cw_t z_s [1:rpaa_pkg::CordicSteps];

	assign cx[0] = rpaa_pkg::CordicGain;
	assign cy[0] = '0;
	assign cz[0] = rpaa_pkg::CwW'({in_ang[13:0], 16'd0});

	for (genvar k = 1; k <= rpaa_pkg::CordicSteps; k++) begin : g_cordic
		rpaa_pkg::cw_t dx, dy, at;
		assign dx = cy[k-1] >>> (k - 1);
		assign dy = cx[k-1] >>> (k - 1);
		assign at = rpaa_pkg::atan_of(5'(k - 1));

		always_ff @(posedge clk) begin
			if (en) begin
				if (!cz[k-1][rpaa_pkg::CwW-1]) begin
					x_s[k] <= cx[k-1] - dx;
					y_s[k] <= cy[k-1] + dy;
					z_s[k] <= cz[k-1] - at;
				end else begin
					x_s[k] <= cx[k-1] + dx;
					y_s[k] <= cy[k-1] - dy;
					z_s[k] <= cz[k-1] + at;
				end
			end
		end

		assign cx[k] = x_s[k];
		assign cy[k] = y_s[k];
		assign cz[k] = z_s[k];
	end

	// Stage 25: round to Q16 and fold in the quadrant.
	localparam int Last = rpaa_pkg::CordicSteps;
	logic signed [17:0] cr0, sr0, cq, sq;
	logic signed [17:0] c_s25, s_s25;

	always_comb begin
		cr0 = rpaa_pkg::trig_q16(x_s[Last]);
		sr0 = rpaa_pkg::trig_q16(y_s[Last]);
		unique case (dl_s[Last].quad)
			2'd1:    begin cq = -sr0; sq = cr0;  end
			2'd2:    begin cq = -cr0; sq = -sr0; end
			2'd3:    begin cq = sr0;  sq = -cr0; end
			default: begin cq = cr0;  sq = sr0;  end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s25 <= cq;
			s_s25 <= sq;
		end
	end

	// Stage 26: first products that need sine and cosine, and the axis-by-dot products.
	logic signed [58:0] crs_s26 [3];
	logic signed [43:0] ad_s26  [3];
	logic signed [41:0] pc_s26  [3];
	logic signed [18:0] omc_s26;

	always_ff @(posedge clk) begin
		if (en) begin
			crs_s26[0] <= dl_s[Last+1].crx * s_s25;
			crs_s26[1] <= dl_s[Last+1].cry * s_s25;
			crs_s26[2] <= dl_s[Last+1].crz * s_s25;
			ad_s26[0]  <= dl_s[Last+1].ax * dl_s[Last+1].dot;
			ad_s26[1]  <= dl_s[Last+1].ay * dl_s[Last+1].dot;
			ad_s26[2]  <= dl_s[Last+1].az * dl_s[Last+1].dot;
			pc_s26[0]  <= dl_s[Last+1].px * c_s25;
			pc_s26[1]  <= dl_s[Last+1].py * c_s25;
			pc_s26[2]  <= dl_s[Last+1].pz * c_s25;
			omc_s26    <= 19'sd65536 - 19'(c_s25);
		end
	end

	// Stage 27: scale by (1 - cos) and align the cosine term to Q46.
	logic signed [58:0] t1_s27 [3];
	logic signed [62:0] t2_s27 [3];
	logic signed [55:0] t3_s27 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				t1_s27[i] <= crs_s26[i];
				t2_s27[i] <= ad_s26[i] * omc_s26;
				t3_s27[i] <= 56'(pc_s26[i]) <<< 14;
			end
		end
	end

	// Stage 28: sum, round and saturate into the output register.
	logic signed [23:0] r_s28 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				r_s28[i] <= rpaa_pkg::round_sat(64'(t1_s27[i]) + 64'(t2_s27[i])
					+ 64'(t3_s27[i]));
			end
		end
	end

	assign m_tdata = {r_s28[2], r_s28[1], r_s28[0]};

`ifndef ASSERT_OFF
	// Sine and cosine never exceed one unit after rounding.
	a_trig_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[Last+1] |-> (c_s25 <= 18'sd65536 && c_s25 >= -18'sd65536
			&& s_s25 <= 18'sd65536 && s_s25 >= -18'sd65536))
		else $error("trig value out of range");

	// One minus cosine stays within [0, 2] units.
	a_omc_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[Last+2] |-> (omc_s26 >= 19'sd0 && omc_s26 <= 19'sd131072))
		else $error("one minus cosine out of range");

	// A held output freezes the whole pipe, input side included.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> ($stable(vld_s) && $stable(m_tdata)))
		else $error("pipeline moved while output stalled");

	// An accepted beat shows up as valid in stage 1 on the next edge.
	a_accept_stage1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> vld_s[1])
		else $error("accepted beat lost at stage 1");
`endif

endmodule
